[design/rcsk_pkg.sv]
package rcsk_pkg;

  localparam int MaxRows     = 256;
  localparam int MaxRankCols = 8;
  localparam int MaxCatCols  = 8;
  localparam int RowW        = 8;
  localparam int ColW        = 3;
  localparam int RankW       = 9;
  localparam int CatW        = 8;
  localparam int NW          = 9;
  localparam int CntW        = 4;
  localparam int SimW        = 17;
  localparam int AddrW       = RowW + ColW;
  localparam int DepthW      = 2;
  localparam int Depth       = 4;

  localparam logic [1:0] ReqLoadRank = 2'd0;
  localparam logic [1:0] ReqLoadCat  = 2'd1;
  localparam logic [1:0] ReqQuery    = 2'd2;

  localparam logic [1:0] CfgRowCount = 2'd0;
  localparam logic [1:0] CfgRankCols = 2'd1;
  localparam logic [1:0] CfgCatCols  = 2'd2;

  localparam logic [SimW-1:0] OneFx = 17'h10000;

  typedef enum logic [1:0] {
    CmdLoadRank = 2'd0,
    CmdLoadCat  = 2'd1,
    CmdQuery    = 2'd2,
    CmdError    = 2'd3
  } cmd_e;

  // One classified request passed from the front end to the back end.
  typedef struct packed {
    cmd_e             cmd;
    logic [RowW-1:0]  row_a;
    logic [RowW-1:0]  row_b;
    logic [ColW-1:0]  column;
    logic [RankW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [NW-1:0]   n;
    logic [CntW-1:0] pr;
    logic [CntW-1:0] pc;
  } cfg_t;

endpackage

[design/rcsk_front.sv]
module rcsk_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           req_type_i,
  input  logic [7:0]           row_a_i,
  input  logic [7:0]           row_b_i,
  input  logic [2:0]           column_i,
  input  logic [8:0]           value_i,
  input  rcsk_pkg::cfg_t       cfg_i,
  output logic                 q_valid_o,
  input  logic                 q_ready_i,
  output rcsk_pkg::cmd_t       q_cmd_o
);

  rcsk_pkg::cmd_t q_mem [rcsk_pkg::Depth];
  logic [rcsk_pkg::DepthW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [rcsk_pkg::DepthW:0]   cnt_q, cnt_d;
  logic push, pop, keep;
  rcsk_pkg::cmd_t cmd;

  always_comb begin
    cmd.row_a  = row_a_i;
    cmd.row_b  = row_b_i;
    cmd.column = column_i;
    cmd.value  = value_i;
    keep = 1'b1;
    case (req_type_i)
      rcsk_pkg::ReqLoadRank: cmd.cmd = rcsk_pkg::CmdLoadRank;
      rcsk_pkg::ReqLoadCat:  cmd.cmd = rcsk_pkg::CmdLoadCat;
      rcsk_pkg::ReqQuery: begin
        if ({1'b0, row_a_i} >= cfg_i.n || {1'b0, row_b_i} >= cfg_i.n) begin
          cmd.cmd = rcsk_pkg::CmdError;
        end else begin
          cmd.cmd = rcsk_pkg::CmdQuery;
        end
      end
      default: begin
        cmd.cmd = rcsk_pkg::CmdLoadRank;
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready  = (cnt_q != (rcsk_pkg::DepthW+1)'(rcsk_pkg::Depth));
  assign push      = in_valid && in_ready && keep;
  assign q_valid_o = (cnt_q != '0);
  assign pop       = q_valid_o && q_ready_i;
  assign q_cmd_o   = q_mem[rd_q];
  assign wr_d      = push ? wr_q + rcsk_pkg::DepthW'(1) : wr_q;
  assign rd_d      = pop ? rd_q + rcsk_pkg::DepthW'(1) : rd_q;
  assign cnt_d     = cnt_q + {{rcsk_pkg::DepthW{1'b0}}, push}
                           - {{rcsk_pkg::DepthW{1'b0}}, pop};

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[design/rcsk_back.sv]
module rcsk_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_ready_o,
  input  rcsk_pkg::cmd_t       q_cmd_i,
  input  rcsk_pkg::cfg_t       cfg_i,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [16:0]          similarity_o,
  output logic                 row_error_o
);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StRead  = 7'b0000010,
    StAccum = 7'b0000100,
    StMul   = 7'b0001000,
    StDiv   = 7'b0010000,
    StFin   = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  logic [rcsk_pkg::RankW-1:0] rank_mem [rcsk_pkg::MaxRows*rcsk_pkg::MaxRankCols];
  logic [rcsk_pkg::CatW-1:0]  cat_mem  [rcsk_pkg::MaxRows*rcsk_pkg::MaxCatCols];

  state_e state_q, state_d;
  rcsk_pkg::cmd_t cmd_q;
  logic [3:0]  k_q, k_d;
  logic        rd_vld_q, rd_cat_q;
  logic [8:0]  ra_q, rb_q;
  logic [7:0]  ca_q, cb_q;
  logic [11:0] sum_q;
  logic [3:0]  mis_q;
  logic [4:0]  p;
  logic [31:0] num_q;
  logic [13:0] den_q;
  logic [31:0] rem_q;
  logic [17:0] quo_q;
  logic [4:0]  bit_q;
  logic [16:0] sim_q;
  logic        err_q;
  logic        k_in_rank;
  logic [2:0]  kc;
  logic [32:0] trial;

  assign p = {1'b0, cfg_i.pr} + {1'b0, cfg_i.pc};
  assign k_in_rank = (k_q < cfg_i.pr);
  assign kc = k_in_rank ? k_q[2:0] : 3'(k_q - cfg_i.pr);
  assign q_ready_o = (state_q == StIdle);
  assign out_valid = (state_q == StOut);
  assign similarity_o = sim_q;
  assign row_error_o = err_q;
  assign trial = {1'b0, rem_q} - ({19'd0, den_q} << bit_q);

  // Loads write the tables straight from the queue head; queries read both rows'
  // rank and category entries per cycle, one column per step.
  always_ff @(posedge clk_i) begin
    if (q_valid_i && q_ready_o && q_cmd_i.cmd == rcsk_pkg::CmdLoadRank) begin
      rank_mem[{q_cmd_i.row_a, q_cmd_i.column}] <= q_cmd_i.value;
    end
    if (q_valid_i && q_ready_o && q_cmd_i.cmd == rcsk_pkg::CmdLoadCat) begin
      cat_mem[{q_cmd_i.row_a, q_cmd_i.column}] <= q_cmd_i.value[7:0];
    end
    ra_q <= rank_mem[{cmd_q.row_a, kc}];
    rb_q <= rank_mem[{cmd_q.row_b, kc}];
    ca_q <= cat_mem[{cmd_q.row_a, kc}];
    cb_q <= cat_mem[{cmd_q.row_b, kc}];
  end

  always_comb begin
    state_d = state_q;
    k_d = k_q;
    case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          case (q_cmd_i.cmd)
            rcsk_pkg::CmdQuery: state_d = (p == 5'd0) ? StFin : StRead;
            rcsk_pkg::CmdError: state_d = StFin;
            default: state_d = StIdle;
          endcase
          k_d = '0;
        end
      end
      StRead: begin
        k_d = k_q + 4'd1;
        if ({1'b0, k_q} + 5'd1 >= p) begin
          state_d = StAccum;
        end
      end
      StAccum: state_d = StMul;
      StMul:   state_d = StDiv;
      StDiv:   if (bit_q == 5'd0) state_d = StFin;
      StFin:   state_d = StOut;
      StOut:   if (out_ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      k_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q <= k_d;
      rd_vld_q <= (state_q == StRead);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_cat_q <= !k_in_rank;
    case (state_q)
      StIdle: begin
        cmd_q <= q_cmd_i;
        sum_q <= '0;
        mis_q <= '0;
        err_q <= (q_cmd_i.cmd == rcsk_pkg::CmdError);
      end
      StMul: begin
        // num = 32768 * (2S + M*N); both parts fit in 32 bits.
        num_q <= {({8'd0, sum_q, 1'b0} + 21'({17'd0, mis_q} * {12'd0, cfg_i.n})),
                  11'd0} << 4;
        den_q <= 14'({5'd0, cfg_i.n} * {9'd0, p});
        bit_q <= 5'd17;
        quo_q <= '0;
        rem_q <= '0;
      end
      StDiv: begin
        if (bit_q == 5'd17) begin
          rem_q <= num_q;
        end
        bit_q <= bit_q - 5'd1;
        if (!trial[32]) begin
          rem_q <= trial[31:0];
          quo_q[bit_q] <= 1'b1;
        end
      end
      StFin: begin
        if (err_q) sim_q <= '0;
        else if (p == 5'd0) sim_q <= rcsk_pkg::OneFx;
        else if (quo_q >= 18'(rcsk_pkg::OneFx)) sim_q <= '0;
        else sim_q <= rcsk_pkg::OneFx - quo_q[16:0];
      end
      default: ;
    endcase
    if (rd_vld_q) begin
      if (rd_cat_q) begin
        mis_q <= mis_q + {3'd0, ca_q != cb_q};
      end else begin
        sum_q <= sum_q + 12'((ra_q > rb_q) ? ra_q - rb_q : rb_q - ra_q);
      end
    end
  end

endmodule

[design/rank_category_similarity_kernel.sv]
// A query steps through reading its P columns, accumulating, multiplying, dividing
// and finishing; a query with a row error or with no columns goes straight to finishing.
// Loads are written by the back end while it is idle; the four-entry queue decouples intake.
// The back end handles one query at a time and takes no new request before its result is taken.
// Reset (rst_ni, asynchronous, active low) empties the queue and restores the
// registers to row_count 256, rank_columns 1, category_columns 0; tables are not cleared.
module rank_category_similarity_kernel (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  row_a_i,
  input  logic [7:0]  row_b_i,
  input  logic [2:0]  column_i,
  input  logic [8:0]  value_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] similarity_o,
  output logic        row_error_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);

  rcsk_pkg::cfg_t cfg_q;
  rcsk_pkg::cmd_t q_cmd;
  logic q_valid, q_ready;

  // Row count writes clamp at 256; column count writes give 8 if bit 3 is set, else bits 3:0.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.n  <= 9'd256;
      cfg_q.pr <= 4'd1;
      cfg_q.pc <= 4'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rcsk_pkg::CfgRowCount: cfg_q.n  <= (cfg_data_i > 9'(rcsk_pkg::MaxRows)) ?
                                           9'(rcsk_pkg::MaxRows) : cfg_data_i;
        rcsk_pkg::CfgRankCols: cfg_q.pr <= cfg_data_i[3] ? 4'd8 : cfg_data_i[3:0];
        rcsk_pkg::CfgCatCols:  cfg_q.pc <= cfg_data_i[3] ? 4'd8 : cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  rcsk_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .req_type_i, .row_a_i, .row_b_i,
    .column_i, .value_i, .cfg_i(cfg_q), .q_valid_o(q_valid), .q_ready_i(q_ready),
    .q_cmd_o(q_cmd)
  );

  rcsk_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_cmd_i(q_cmd),
    .cfg_i(cfg_q), .out_valid, .out_ready, .similarity_o, .row_error_o
  );

endmodule

[design/rcsk_checker.sv]
module rcsk_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] similarity_o,
  input logic        row_error_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(similarity_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && row_error_o |-> similarity_o == 17'd0)
    else $error("error result with nonzero similarity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> similarity_o <= 17'h10000)
    else $error("similarity above one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready |=> !out_valid)
    else $error("results back to back");

endmodule

bind rank_category_similarity_kernel rcsk_checker u_rcsk_checker (.*);

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int HoldCycles    = 64;
  localparam int WatchdogLimit = 20000;

  // One row of the directed stimulus table. A row with has_fixed set carries an
  // expected result that is obvious without the predictor.
  typedef struct {
    logic [1:0]                row_req;
    logic [7:0]                row_a;
    logic [7:0]                row_b;
    logic [2:0]                column;
    logic [8:0]                value;
    bit                        has_fixed;
    logic [rcsk_pkg::SimW-1:0] fixed_sim;
    logic                      fixed_err;
  } stim_row_t;

  typedef struct packed {
    logic [rcsk_pkg::SimW-1:0] sim;
    logic                      err;
  } kernel_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  req_type_i;
  logic [7:0]  row_a_i;
  logic [7:0]  row_b_i;
  logic [2:0]  column_i;
  logic [8:0]  value_i;
  logic        out_valid;
  logic        out_ready;
  logic [16:0] similarity_o;
  logic        row_error_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [8:0]  cfg_data_i;

  // Shadow copies of the block's tables and registers, as the predictor sees them.
  logic [rcsk_pkg::RankW-1:0] rank_shadow [rcsk_pkg::MaxRows*rcsk_pkg::MaxRankCols];
  logic [rcsk_pkg::CatW-1:0]  cat_shadow  [rcsk_pkg::MaxRows*rcsk_pkg::MaxCatCols];
  logic [8:0]       row_count_reg;
  logic [3:0]       rank_cols_reg;
  logic [3:0]       cat_cols_reg;

  kernel_result_t pending_results [$];
  int  fail_count;
  int  idle_cycles;
  stim_row_t directed_rows [$];

  rank_category_similarity_kernel dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type_i  (req_type_i),
    .row_a_i     (row_a_i),
    .row_b_i     (row_b_i),
    .column_i    (column_i),
    .value_i     (value_i),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .similarity_o(similarity_o),
    .row_error_o (row_error_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Effective sizes: oversized register values saturate at the table maxima.
  function automatic int eff_rows();
    return (row_count_reg > rcsk_pkg::MaxRows) ? rcsk_pkg::MaxRows : int'(row_count_reg);
  endfunction

  function automatic int eff_rank_cols();
    return (rank_cols_reg > rcsk_pkg::MaxRankCols) ? rcsk_pkg::MaxRankCols
                                                   : int'(rank_cols_reg);
  endfunction

  function automatic int eff_cat_cols();
    return (cat_cols_reg > rcsk_pkg::MaxCatCols) ? rcsk_pkg::MaxCatCols
                                                 : int'(cat_cols_reg);
  endfunction

  // Similarity for a pair of rows: the subtracted term is floored in 1/65536
  // units before it is taken from one, and saturates the result at zero.
  function automatic kernel_result_t gower_similarity(logic [7:0] a, logic [7:0] b);
    kernel_result_t res;
    longint unsigned diff_sum;
    longint unsigned mism;
    longint unsigned term;
    int n;
    int pr;
    int pc;
    int x;
    int y;
    n = eff_rows();
    pr = eff_rank_cols();
    pc = eff_cat_cols();
    diff_sum = 0;
    mism = 0;
    res.err = 1'b0;
    res.sim = '0;
    if (a >= n || b >= n) begin
      res.err = 1'b1;
      return res;
    end
    if (pr + pc == 0) begin
      res.sim = rcsk_pkg::OneFx;
      return res;
    end
    for (int k = 0; k < pr; k++) begin
      x = rank_shadow[a*rcsk_pkg::MaxRankCols+k];
      y = rank_shadow[b*rcsk_pkg::MaxRankCols+k];
      diff_sum += (x > y) ? x - y : y - x;
    end
    for (int k = 0; k < pc; k++) begin
      if (cat_shadow[a*rcsk_pkg::MaxCatCols+k] != cat_shadow[b*rcsk_pkg::MaxCatCols+k])
        mism++;
    end
    term = (64'd32768 * (2 * diff_sum + mism * n)) / (longint'(n) * (pr + pc));
    res.sim = (term >= 65536) ? '0 : rcsk_pkg::SimW'(65536 - term);
    return res;
  endfunction

  // Updates the shadow tables for an accepted load; queues a result for a query.
  task automatic apply_request(logic [1:0] req, logic [7:0] a, logic [7:0] b,
                               logic [2:0] col, logic [8:0] val);
    case (req)
      rcsk_pkg::ReqLoadRank: rank_shadow[a*rcsk_pkg::MaxRankCols+col] = val;
      rcsk_pkg::ReqLoadCat:  cat_shadow[a*rcsk_pkg::MaxCatCols+col] = val[7:0];
      rcsk_pkg::ReqQuery:    pending_results.push_back(gower_similarity(a, b));
      default: ;
    endcase
  endtask

  // Sends one request with the valid/ready handshake and applies it on acceptance.
  task automatic send_request(logic [1:0] req, logic [7:0] a, logic [7:0] b,
                              logic [2:0] col, logic [8:0] val);
    req_type_i <= req;
    row_a_i    <= a;
    row_b_i    <= b;
    column_i   <= col;
    value_i    <= val;
    in_valid   <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    apply_request(req, a, b, col, val);
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  task automatic write_register(logic [1:0] idx, logic [8:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      rcsk_pkg::CfgRowCount: row_count_reg = data;
      rcsk_pkg::CfgRankCols: rank_cols_reg = data[3:0];
      rcsk_pkg::CfgCatCols:  cat_cols_reg  = data[3:0];
      default: ;
    endcase
  endtask

  // Waits until every queued result has come back, then lets the back end drain.
  task automatic wait_until_drained();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (HoldCycles) @(negedge clk_i);
  endtask

  // Fills all columns of the given number of rows from row zero so that queries never
  // read an entry that was never written.
  task automatic fill_table(int rows);
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < rcsk_pkg::MaxRankCols; c++)
        send_request(rcsk_pkg::ReqLoadRank, 8'(r), 8'($urandom), 3'(c),
                     9'($urandom_range(0, 256)));
      for (int c = 0; c < rcsk_pkg::MaxCatCols; c++)
        send_request(rcsk_pkg::ReqLoadCat, 8'(r), 8'($urandom), 3'(c),
                     9'($urandom_range(0, 3)));
    end
  endtask

  function automatic stim_row_t make_row(logic [1:0] req, int a, int b, int col, int val,
                                         bit fixed = 0, int sim = 0, bit err = 0);
    stim_row_t row;
    row.row_req = req;
    row.row_a = 8'(a);
    row.row_b = 8'(b);
    row.column = 3'(col);
    row.value = 9'(val);
    row.has_fixed = fixed;
    row.fixed_sim = rcsk_pkg::SimW'(sim);
    row.fixed_err = err;
    return row;
  endfunction

  // Result checker: each accepted result is compared to the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result sim=%0d err=%0b", $time, similarity_o, row_error_o);
        fail_count++;
      end else begin
        kernel_result_t exp_res;
        exp_res = pending_results.pop_front();
        if (similarity_o !== exp_res.sim) begin
          $display("%0t: similarity mismatch expected %0d actual %0d",
                   $time, exp_res.sim, similarity_o);
          fail_count++;
        end
        if (row_error_o !== exp_res.err) begin
          $display("%0t: row_error mismatch expected %0b actual %0b",
                   $time, exp_res.err, row_error_o);
          fail_count++;
        end
      end
    end
  end

  // Receiver stall pattern: long ready stretches alternate with random stalls.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (($time / 2000) % 3 == 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Watchdog: counts cycles with results pending but no accepted request, result or register write.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we_i ||
        pending_results.size() == 0) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int burst;
    int rows_in_use;
    int sent;
    int roll;
    logic [1:0] rq;
    logic [8:0] v;
    fail_count = 0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    req_type_i = '0;
    row_a_i = '0;
    row_b_i = '0;
    column_i = '0;
    value_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    row_count_reg = 9'd256;
    rank_cols_reg = 4'd1;
    cat_cols_reg = 4'd0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part under reset settings: one rank column, no category columns.
    directed_rows.push_back(make_row(rcsk_pkg::ReqLoadRank, 0, 0, 0, 0));
    directed_rows.push_back(make_row(rcsk_pkg::ReqLoadRank, 255, 0, 0, 256));
    directed_rows.push_back(make_row(rcsk_pkg::ReqLoadRank, 1, 0, 0, 0));
    // Identical rows give exactly one.
    directed_rows.push_back(make_row(rcsk_pkg::ReqQuery, 0, 1, 0, 0, 1, 65536, 0));
    // Rank extremes: floor(65536*256/256) is the full term, so the result is zero.
    directed_rows.push_back(make_row(rcsk_pkg::ReqQuery, 0, 255, 0, 0, 1, 0, 0));
    directed_rows.push_back(make_row(rcsk_pkg::ReqQuery, 255, 255, 7, 511, 1, 65536, 0));
    directed_rows.push_back(make_row(rcsk_pkg::ReqLoadCat, 0, 0, 0, 256));
    directed_rows.push_back(make_row(rcsk_pkg::ReqLoadCat, 1, 0, 0, 0));
    directed_rows.push_back(make_row(rcsk_pkg::ReqLoadCat, 255, 0, 7, 255));
    directed_rows.push_back(make_row(rcsk_pkg::ReqLoadRank, 2, 0, 0, 100));
    directed_rows.push_back(make_row(rcsk_pkg::ReqQuery, 0, 2, 0, 0));
    // Unused request type does nothing.
    directed_rows.push_back(make_row(2'd3, 255, 255, 7, 511));
    foreach (directed_rows[i]) begin
      stim_row_t row;
      row = directed_rows[i];
      send_request(row.row_req, row.row_a, row.row_b, row.column, row.value);
      if (row.has_fixed) begin
        kernel_result_t pred;
        pred = pending_results[pending_results.size()-1];
        if (pred.sim !== row.fixed_sim || pred.err !== row.fixed_err) begin
          $display("%0t: table row %0d expected %0d/%0b predicted %0d/%0b", $time, i,
                   row.fixed_sim, row.fixed_err, pred.sim, pred.err);
          fail_count++;
        end
      end
    end
    wait_until_drained();

    // Row count below the queried rows gives an error flag; zero rows fails everything.
    write_register(rcsk_pkg::CfgRowCount, 9'd2);
    send_request(rcsk_pkg::ReqQuery, 8'd1, 8'd2, 3'd0, 9'd0);
    send_request(rcsk_pkg::ReqQuery, 8'd255, 8'd0, 3'd0, 9'd0);
    wait_until_drained();
    write_register(rcsk_pkg::CfgRowCount, 9'd0);
    send_request(rcsk_pkg::ReqQuery, 8'd0, 8'd0, 3'd0, 9'd0);
    wait_until_drained();
    // Zero columns gives exactly one.
    write_register(rcsk_pkg::CfgRowCount, 9'd256);
    write_register(rcsk_pkg::CfgRankCols, 9'd0);
    write_register(rcsk_pkg::CfgCatCols, 9'd0);
    send_request(rcsk_pkg::ReqQuery, 8'd0, 8'd255, 3'd0, 9'd0);
    wait_until_drained();

    // Random phases: each phase picks settings, fills the rows in use, then
    // mixes queries with loads inside those rows and some noise.
    sent = 0;
    for (int phase = 0; sent < 1800; phase++) begin
      case (phase % 4)
        0: write_register(rcsk_pkg::CfgRowCount, 9'($urandom_range(1, 8)));
        1: write_register(rcsk_pkg::CfgRowCount, 9'(511 - $urandom_range(0, 200)));
        2: write_register(rcsk_pkg::CfgRowCount, 9'd1);
        default: write_register(rcsk_pkg::CfgRowCount, 9'($urandom_range(2, 16)));
      endcase
      write_register(rcsk_pkg::CfgRankCols,
                     (phase % 5 == 0) ? 9'd15 : 9'($urandom_range(0, 8)));
      write_register(rcsk_pkg::CfgCatCols,
                     (phase % 6 == 0) ? 9'd15 : 9'($urandom_range(0, 8)));
      rows_in_use = (eff_rows() > 16) ? 16 : eff_rows();
      fill_table(rows_in_use);
      sent += rows_in_use * (rcsk_pkg::MaxRankCols + rcsk_pkg::MaxCatCols);
      for (int k = 0; k < 150; ) begin
        burst = $urandom_range(1, 12);
        for (int j = 0; j < burst && k < 150; j++, k++) begin
          roll = $urandom_range(0, 99);
          v = (roll % 2) ? 9'($urandom_range(0, 256)) : 9'($urandom_range(0, 2));
          if (roll < 60) begin
            // Mostly valid rows, sometimes a row at or beyond the row count for
            // the error flag.
            rq = rcsk_pkg::ReqQuery;
            send_request(rq, 8'((roll < 52 || eff_rows() > 255)
                                ? $urandom_range(0, rows_in_use - 1)
                                : $urandom_range(eff_rows(), 255)),
                         8'($urandom_range(0, rows_in_use - 1)), 3'($urandom), 9'($urandom));
          end else if (roll < 95) begin
            send_request((roll < 78) ? rcsk_pkg::ReqLoadRank : rcsk_pkg::ReqLoadCat,
                         8'($urandom_range(0, rows_in_use - 1)), 8'($urandom),
                         3'($urandom), v);
          end else begin
            // Loads far above the rows in use are never queried in this phase,
            // and the unused request type is ignored.
            send_request((roll < 98) ? 2'($urandom_range(0, 1)) : 2'd3,
                         8'($urandom_range(200, 255)), 8'($urandom), 3'($urandom),
                         9'($urandom));
          end
          sent++;
        end
        repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 30)) @(negedge clk_i);
      end
      if (phase % 3 == 1) wait_until_drained();
      // The sender holds off until the block has returned everything before
      // the next register writes.
      wait_until_drained();
    end

    wait_until_drained();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
design/rcsk_pkg.sv
design/rcsk_front.sv
design/rcsk_back.sv
design/rank_category_similarity_kernel.sv
design/rcsk_checker.sv
test/testbench.sv
